FILE: rtl/assert_macros.svh
// Assertion macros for the engine RTL, included by c2oe_seq.
// Plain text header, no dependencies; include it inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under a synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/c2oe_pkg.sv
// Shared types and codes for the 2-D convolution output engine.
// No dependencies; every engine module imports it.
package c2oe_pkg;

  // Operation codes carried in tuser of the input stream.
  localparam logic [1:0] OP_LOAD_ACT  = 2'd0;
  localparam logic [1:0] OP_LOAD_WGT  = 2'd1;
  localparam logic [1:0] OP_LOAD_BIAS = 2'd2;
  localparam logic [1:0] OP_COMPUTE   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_IN_CHANNELS   = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [2:0] REG_IN_WIDTH      = 3'd2;
  localparam logic [2:0] REG_FILTER_COUNT  = 3'd3;
  localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd4;
  localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd5;
  localparam logic [2:0] REG_STRIDE_STEP   = 3'd6;
  localparam logic [2:0] REG_ZERO_PAD      = 3'd7;

  localparam int CFG_DW   = 6;
  localparam int ACC_W    = 48;
  localparam int STRIDE_MAX = 8;
  localparam int PAD_MAX    = 6;

  // Current geometry plus values derived from it.
  typedef struct packed {
    logic [4:0]        c;
    logic [5:0]        h;
    logic [5:0]        w;
    logic [4:0]        f;
    logic [2:0]        kh;
    logic [2:0]        kw;
    logic [3:0]        s;
    logic [2:0]        p;
    logic [11:0]       hw;
    logic signed [7:0] span_h;
    logic signed [7:0] span_w;
  } geom_t;

  // Store write request from an accepted load transfer.
  typedef struct packed {
    logic               en;
    logic [1:0]         op;
    logic [13:0]        addr;
    logic signed [15:0] value;
  } wr_req_t;

  // Sequencer controls for the store and the accumulator.
  typedef struct packed {
    logic init;
    logic tap;
    logic push;
    logic oor;
  } ctl_t;

  // Accumulator status back to the sequencer.
  typedef struct packed {
    logic busy;
    logic out_free;
  } mac_stat_t;

endpackage

FILE: rtl/c2oe_cfg.sv
// Configuration registers with range clamping and derived geometry.
// Depends on c2oe_pkg.
module c2oe_cfg
  import c2oe_pkg::*;
#(
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_SIDE     = 32,
  parameter int MAX_FILTERS  = 16,
  parameter int MAX_KERNEL   = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output geom_t             geom
);

  logic [4:0] c, f;
  logic [5:0] h, w;
  logic [2:0] kh, kw, p;
  logic [3:0] s;
  logic [11:0] hw;
  logic signed [7:0] span_h, span_w;

  function automatic logic [7:0] clamp_u(input logic [7:0] v, input int lo, input int hi);
    logic [7:0] r;
    r = v;
    if (int'(v) < lo) r = 8'(lo);
    if (int'(v) > hi) r = 8'(hi);
    return r;
  endfunction

  // Register writes, each value clamped to its legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      c  <= 5'd1;
      h  <= 6'd1;
      w  <= 6'd1;
      f  <= 5'd1;
      kh <= 3'd1;
      kw <= 3'd1;
      s  <= 4'd1;
      p  <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_CHANNELS:   c  <= 5'(clamp_u({3'b0, cfg_data[4:0]}, 1, MAX_CHANNELS));
        REG_IN_HEIGHT:     h  <= 6'(clamp_u({2'b0, cfg_data[5:0]}, 1, MAX_SIDE));
        REG_IN_WIDTH:      w  <= 6'(clamp_u({2'b0, cfg_data[5:0]}, 1, MAX_SIDE));
        REG_FILTER_COUNT:  f  <= 5'(clamp_u({3'b0, cfg_data[4:0]}, 1, MAX_FILTERS));
        REG_KERNEL_HEIGHT: kh <= 3'(clamp_u({5'b0, cfg_data[2:0]}, 1, MAX_KERNEL));
        REG_KERNEL_WIDTH:  kw <= 3'(clamp_u({5'b0, cfg_data[2:0]}, 1, MAX_KERNEL));
        REG_STRIDE_STEP:   s  <= 4'(clamp_u({4'b0, cfg_data[3:0]}, 1, STRIDE_MAX));
        REG_ZERO_PAD:      p  <= 3'(clamp_u({5'b0, cfg_data[2:0]}, 0, PAD_MAX));
        default: ;
      endcase
    end
  end

  // Derived values, registered from the configuration and refreshed every cycle.
  always_ff @(posedge clk) begin
    hw     <= 12'(h) * 12'(w);
    span_h <= $signed({2'b0, h}) + $signed({4'b0, p, 1'b0}) - $signed({5'b0, kh});
    span_w <= $signed({2'b0, w}) + $signed({4'b0, p, 1'b0}) - $signed({5'b0, kw});
  end

  always_comb begin
    geom.c      = c;
    geom.h      = h;
    geom.w      = w;
    geom.f      = f;
    geom.kh     = kh;
    geom.kw     = kw;
    geom.s      = s;
    geom.p      = p;
    geom.hw     = hw;
    geom.span_h = span_h;
    geom.span_w = span_w;
  end

endmodule

FILE: rtl/c2oe_store.sv
// Activation and weight stores, single port, and a bias store, all with registered read data.
// Depends on c2oe_pkg; the bias store has valid bits cleared by reset.
module c2oe_store
  import c2oe_pkg::*;
#(
  parameter int ACT_DEPTH   = 16384,
  parameter int WGT_DEPTH   = 12544,
  parameter int MAX_FILTERS = 16,
  parameter int AAW         = 14,
  parameter int WAW         = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  wr_req_t            wr,
  input  ctl_t               ctl,
  input  logic [AAW-1:0]     act_addr,
  input  logic [WAW-1:0]     wt_addr,
  input  logic [3:0]         bias_addr,
  output logic signed [15:0] act_q,
  output logic signed [15:0] wt_q,
  output logic signed [15:0] bias_q
);

  localparam int FW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

  logic signed [15:0] act_mem  [ACT_DEPTH];
  logic signed [15:0] wt_mem   [WGT_DEPTH];
  logic signed [15:0] bias_mem [MAX_FILTERS];
  logic               bias_vld [MAX_FILTERS];

  logic act_we, wt_we, bias_we;
  logic [FW-1:0] bias_wr_idx, bias_rd_idx;

  // Loads beyond a store's depth are dropped.
  assign act_we  = wr.en && (wr.op == OP_LOAD_ACT)  && (int'(wr.addr) < ACT_DEPTH);
  assign wt_we   = wr.en && (wr.op == OP_LOAD_WGT)  && (int'(wr.addr) < WGT_DEPTH);
  assign bias_we = wr.en && (wr.op == OP_LOAD_BIAS) && (int'(wr.addr) < MAX_FILTERS);
  assign bias_wr_idx = FW'(wr.addr);
  assign bias_rd_idx = FW'(bias_addr);

  // Loads only arrive while the sequencer is idle, so a port never sees
  // a write and a read in the same cycle.
  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[AAW'(wr.addr)] <= wr.value;
    end else if (ctl.tap) begin
      act_q <= act_mem[act_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[WAW'(wr.addr)] <= wr.value;
    end else if (ctl.tap) begin
      wt_q <= wt_mem[wt_addr];
    end
  end

  // Bias data and per-entry valid bits; an unwritten entry reads as zero.
  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_mem[bias_wr_idx] <= wr.value;
    end
    bias_q <= bias_vld[bias_rd_idx] ? bias_mem[bias_rd_idx] : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FILTERS; i++) begin
        bias_vld[i] <= 1'b0;
      end
    end else if (bias_we) begin
      bias_vld[bias_wr_idx] <= 1'b1;
    end
  end

endmodule

FILE: rtl/c2oe_mac.sv
// Multiply-accumulate datapath with saturation and the result register.
// Depends on c2oe_pkg; fed by c2oe_store and steered by c2oe_seq.
module c2oe_mac
  import c2oe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  input  logic signed [15:0] act_q,
  input  logic signed [15:0] wt_q,
  input  logic signed [15:0] bias_q,
  input  logic               m_tready,
  output mac_stat_t          stat,
  output logic               m_tvalid,
  output logic [31:0]        sum,
  output logic               out_of_range
);

  logic                    rd_vld, prod_vld;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic [31:0]             sat;

  // Stage valid bits follow the issued reads through the pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= ctl.tap;
      prod_vld <= rd_vld;
    end
  end

  // Product register, then the accumulator.
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= act_q * wt_q;
    end
    if (ctl.init) begin
      acc <= {{(ACC_W - 24){bias_q[15]}}, bias_q, 8'b0};
    end else if (prod_vld) begin
      acc <= acc + {{(ACC_W - 32){prod[31]}}, prod};
    end
  end

  // Saturate to a signed 32-bit Q16.16 result.
  always_comb begin
    if (acc > 48'sh0000_7FFF_FFFF) begin
      sat = 32'h7FFF_FFFF;
    end else if (acc < -48'sh0000_8000_0000) begin
      sat = 32'h8000_0000;
    end else begin
      sat = acc[31:0];
    end
  end

  // Output register holds the result until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      sum          <= ctl.oor ? 32'd0 : sat;
      out_of_range <= ctl.oor;
    end
  end

  assign stat.busy     = rd_vld || prod_vld;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

FILE: rtl/c2oe_seq.sv
// Compute sequencer: setup arithmetic, tap walk and store addressing.
// Depends on c2oe_pkg and assert_macros.svh.
module c2oe_seq
  import c2oe_pkg::*;
#(
  parameter int AAW = 14,
  parameter int WAW = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  geom_t          geom,
  input  logic           start,
  input  logic [3:0]     filter_index,
  input  logic [5:0]     out_row,
  input  logic [5:0]     out_col,
  input  mac_stat_t      stat,
  output logic           idle,
  output ctl_t           ctl,
  output logic [AAW-1:0] act_addr,
  output logic [WAW-1:0] wt_addr,
  output logic [3:0]     bias_addr
);

  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP1 = 3'd1;
  localparam logic [2:0] ST_SETUP2 = 3'd2;
  localparam logic [2:0] ST_SETUP3 = 3'd3;
  localparam logic [2:0] ST_RUN    = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_PUSH   = 3'd6;

  logic [2:0] state;

  logic [3:0]  f_r;
  logic [5:0]  oh_r, ow_r;
  logic [9:0]  ohs, ows;
  logic [8:0]  fc;
  logic [11:0] fck;
  logic signed [10:0] ih0, iw0, ih, iw;
  logic signed [17:0] row0;
  logic signed [18:0] row_addr;
  logic [16:0] chan_base;
  logic [14:0] wi;
  logic [4:0]  c;
  logic [2:0]  kh, kw;
  logic        oor;

  logic [9:0]  ohs_c, ows_c;
  logic [8:0]  fc_c;
  logic [11:0] fck_c;
  logic [14:0] wb_c;
  logic signed [17:0] row0_c;
  logic signed [18:0] act_addr_c;
  logic        in_range;

  // Setup products, one small multiply per register.
  assign ohs_c  = 10'(out_row_r_ext(oh_r)) * 10'(geom.s);
  assign ows_c  = 10'(out_row_r_ext(ow_r)) * 10'(geom.s);
  assign fc_c   = 9'(f_r) * 9'(geom.c);
  assign fck_c  = 12'(fc) * 12'(geom.kh);
  assign wb_c   = 15'(fck) * 15'(geom.kw);
  assign row0_c = $signed({{7{ih0[10]}}, ih0}) * $signed({12'b0, geom.w});

  function automatic logic [5:0] out_row_r_ext(input logic [5:0] v);
    return v;
  endfunction

  // A tap inside the padded border reads the stores; others are skipped.
  assign in_range = (ih >= 11'sd0) && (ih < $signed({5'b0, geom.h})) &&
                    (iw >= 11'sd0) && (iw < $signed({5'b0, geom.w}));
  assign act_addr_c = row_addr + {{8{iw[10]}}, iw};
  assign act_addr   = AAW'($unsigned(act_addr_c));
  assign wt_addr    = WAW'(wi);
  assign bias_addr  = f_r;

  assign idle     = (state == ST_IDLE);
  assign ctl.init = (state == ST_SETUP3) && !oor;
  assign ctl.tap  = (state == ST_RUN) && in_range;
  assign ctl.push = (state == ST_PUSH) && stat.out_free;
  assign ctl.oor  = oor;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:   if (start) state <= ST_SETUP1;
        ST_SETUP1: state <= ST_SETUP2;
        ST_SETUP2: state <= ST_SETUP3;
        ST_SETUP3: state <= oor ? ST_PUSH : ST_RUN;
        ST_RUN: begin
          if ((kw == geom.kw - 3'd1) && (kh == geom.kh - 3'd1) &&
              (c == geom.c - 5'd1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN:  if (!stat.busy) state <= ST_PUSH;
        ST_PUSH:   if (stat.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the setup steps and of the tap walk.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          f_r  <= filter_index;
          oh_r <= out_row;
          ow_r <= out_col;
        end
      end
      ST_SETUP1: begin
        ohs <= ohs_c;
        ows <= ows_c;
        fc  <= fc_c;
      end
      ST_SETUP2: begin
        ih0 <= $signed({1'b0, ohs}) - $signed({8'b0, geom.p});
        iw0 <= $signed({1'b0, ows}) - $signed({8'b0, geom.p});
        fck <= fck_c;
        oor <= ({1'b0, f_r} >= geom.f) ||
               ($signed({1'b0, ohs}) > $signed({{3{geom.span_h[7]}}, geom.span_h})) ||
               ($signed({1'b0, ows}) > $signed({{3{geom.span_w[7]}}, geom.span_w}));
      end
      ST_SETUP3: begin
        row0      <= row0_c;
        row_addr  <= {row0_c[17], row0_c};
        wi        <= wb_c;
        ih        <= ih0;
        iw        <= iw0;
        c         <= 5'd0;
        kh        <= 3'd0;
        kw        <= 3'd0;
        chan_base <= 17'd0;
      end
      ST_RUN: begin
        wi <= wi + 15'd1;
        if (kw != geom.kw - 3'd1) begin
          kw <= kw + 3'd1;
          iw <= iw + 11'sd1;
        end else begin
          kw <= 3'd0;
          iw <= iw0;
          if (kh != geom.kh - 3'd1) begin
            kh       <= kh + 3'd1;
            ih       <= ih + 11'sd1;
            row_addr <= row_addr + $signed({13'b0, geom.w});
          end else begin
            kh <= 3'd0;
            ih <= ih0;
            if (c != geom.c - 5'd1) begin
              c         <= c + 5'd1;
              chan_base <= chan_base + 17'(geom.hw);
              row_addr  <= $signed({2'b0, chan_base}) + $signed({7'b0, geom.hw}) +
                           {row0[17], row0};
            end
          end
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPLY(a_start_idle, clk, rst, start, state == ST_IDLE, "compute started while busy")
  `ASSERT_IMPLY(a_push_free, clk, rst, ctl.push, stat.out_free, "result pushed into full output")
  `ASSERT_NEXT(a_drain_done, clk, rst, (state == ST_DRAIN) && !stat.busy, state == ST_PUSH, "drain did not end")

endmodule

FILE: rtl/conv2d_output_engine_core.sv
// Top level of the 2-D convolution output engine (NCHW, one image).
// Depends on c2oe_pkg, c2oe_cfg, c2oe_store, c2oe_mac and c2oe_seq.
//
//   Channel   Direction  Moves
//   s_*       in         load or compute request, one per transfer
//   m_*       out        one result per compute request
//   cfg_*     in         configuration register write, no read-back
//
// A load is written to its store when accepted. A compute runs its setup
// steps, then the single multiply-accumulate walks every channel and kernel
// tap, one tap per cycle through the activation and weight memory ports, then
// drains and pushes; a compute outside the output skips walk and drain. Taps
// in the zero padding are walked but read nothing. Reset clears only control
// state, configuration and bias valid bits, so there is no clearing pass. While
// the next compute waits to push a result held by m_tready, no load is taken.
module conv2d_output_engine_core
  import c2oe_pkg::*;
#(
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_SIDE     = 32,
  parameter int MAX_FILTERS  = 16,
  parameter int MAX_KERNEL   = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // address[13:0], value[29:14], filter_index[33:30], out_row[39:34],
  // out_col[45:40], zero fill[47:46]
  input  logic [47:0]       s_tdata,
  // operation[1:0]
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // sum[31:0]
  output logic [31:0]       m_tdata,
  // out_of_range[0]
  output logic [0:0]        m_tuser,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int ACT_DEPTH = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
  localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

  geom_t              geom;
  wr_req_t            wr;
  ctl_t               ctl;
  mac_stat_t          stat;
  logic               in_xfer, start, idle, oor_flag;
  logic [AAW-1:0]     act_addr;
  logic [WAW-1:0]     wt_addr;
  logic [3:0]         bias_addr;
  logic signed [15:0] act_q, wt_q, bias_q;
  logic [31:0]        sum;

  // Input transfers: loads write the stores at once, computes start the walk.
  assign s_tready = idle;
  assign in_xfer  = s_tvalid && s_tready;
  assign start    = in_xfer && (s_tuser == OP_COMPUTE);
  assign wr.en    = in_xfer && (s_tuser != OP_COMPUTE);
  assign wr.op    = s_tuser;
  assign wr.addr  = s_tdata[13:0];
  assign wr.value = $signed(s_tdata[29:14]);

  assign m_tdata    = sum;
  assign m_tuser[0] = oor_flag;

  c2oe_cfg #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_SIDE    (MAX_SIDE),
    .MAX_FILTERS (MAX_FILTERS),
    .MAX_KERNEL  (MAX_KERNEL)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .geom     (geom)
  );

  c2oe_store #(
    .ACT_DEPTH  (ACT_DEPTH),
    .WGT_DEPTH  (WGT_DEPTH),
    .MAX_FILTERS(MAX_FILTERS),
    .AAW        (AAW),
    .WAW        (WAW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .ctl      (ctl),
    .act_addr (act_addr),
    .wt_addr  (wt_addr),
    .bias_addr(bias_addr),
    .act_q    (act_q),
    .wt_q     (wt_q),
    .bias_q   (bias_q)
  );

  c2oe_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .act_q       (act_q),
    .wt_q        (wt_q),
    .bias_q      (bias_q),
    .m_tready    (m_tready),
    .stat        (stat),
    .m_tvalid    (m_tvalid),
    .sum         (sum),
    .out_of_range(oor_flag)
  );

  c2oe_seq #(
    .AAW(AAW),
    .WAW(WAW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .start       (start),
    .filter_index(s_tdata[33:30]),
    .out_row     (s_tdata[39:34]),
    .out_col     (s_tdata[45:40]),
    .stat        (stat),
    .idle        (idle),
    .ctl         (ctl),
    .act_addr    (act_addr),
    .wt_addr     (wt_addr),
    .bias_addr   (bias_addr)
  );

endmodule

FILE: test/conv2d_output_engine_core_tb.sv
// Self-checking testbench for conv2d_output_engine_core: a bit-exact convolution
// predictor checks every result against loads and computes sent at random pacing.
// Depends on c2oe_pkg and the engine RTL; needs no files or arguments.
module conv2d_output_engine_core_tb;
  import c2oe_pkg::*;

  localparam int ACT_DEPTH      = 16 * 32 * 32;
  localparam int WGT_DEPTH      = 16 * 16 * 7 * 7;
  localparam int BIAS_DEPTH     = 16;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int SETTLE_CYCLES  = 20;
  localparam longint SUM_MAX    = 64'sd2147483647;
  localparam longint SUM_MIN    = -64'sd2147483648;

  // One request as the host sees it; operation goes in tuser, the rest in tdata.
  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] addr;
    logic [15:0] value;
    logic [3:0]  filt;
    logic [5:0]  row;
    logic [5:0]  col;
  } conv_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        oor;
  } conv_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [47:0]       s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;
  logic [0:0]        m_tuser;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  // Shadow copy of the engine stores and geometry.
  logic signed [15:0] act_image [0:ACT_DEPTH-1];
  logic signed [15:0] filter_weights [0:WGT_DEPTH-1];
  logic signed [15:0] filter_bias [0:BIAS_DEPTH-1];
  int cfg_c = 1, cfg_h = 1, cfg_w = 1, cfg_f = 1;
  int cfg_kh = 1, cfg_kw = 1, cfg_s = 1, cfg_p = 0;

  conv_req_t    request_queue [$];
  conv_result_t expected_sums [$];
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  bit           calm = 1'b0;

  conv2d_output_engine_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int out_size(int size, int k);
    int span;
    span = size + 2 * cfg_p - k;
    return (span < 0) ? 0 : span / cfg_s + 1;
  endfunction

  // Direct convolution at one output point; padding taps contribute nothing.
  function automatic conv_result_t conv_point(conv_req_t r);
    int f, row, col, ih, iw;
    longint acc;
    conv_result_t res;
    f = r.filt;
    row = r.row;
    col = r.col;
    res = '0;
    if (f >= cfg_f || row >= out_size(cfg_h, cfg_kh) || col >= out_size(cfg_w, cfg_kw)) begin
      res.oor = 1'b1;
      return res;
    end
    acc = longint'(filter_bias[f]) * 256;
    for (int c = 0; c < cfg_c; c++) begin
      for (int kh = 0; kh < cfg_kh; kh++) begin
        ih = row * cfg_s + kh - cfg_p;
        if (ih < 0 || ih >= cfg_h) continue;
        for (int kw = 0; kw < cfg_kw; kw++) begin
          iw = col * cfg_s + kw - cfg_p;
          if (iw < 0 || iw >= cfg_w) continue;
          acc += longint'(act_image[(c * cfg_h + ih) * cfg_w + iw]) *
                 longint'(filter_weights[((f * cfg_c + c) * cfg_kh + kh) * cfg_kw + kw]);
        end
      end
    end
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    res.sum = acc[31:0];
    return res;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return $urandom;
    endcase
  endfunction

  // Loads carry random filter and position bits that the engine must ignore.
  task automatic queue_load(logic [1:0] op, int addr, logic [15:0] value);
    conv_req_t r;
    r = $urandom;
    r.op = op;
    r.addr = addr;
    r.value = value;
    request_queue.push_back(r);
  endtask

  // Computes carry random address and value bits that the engine must ignore.
  task automatic queue_compute(int f, int row, int col);
    conv_req_t r;
    r = {$urandom, $urandom};
    r.op = OP_COMPUTE;
    r.filt = f;
    r.row = row;
    r.col = col;
    request_queue.push_back(r);
  endtask

  function automatic conv_req_t random_request();
    conv_req_t r;
    int pick, oh_n, ow_n;
    r = {$urandom, $urandom};
    pick = $urandom_range(99);
    oh_n = out_size(cfg_h, cfg_kh);
    ow_n = out_size(cfg_w, cfg_kw);
    if (pick < 40 && oh_n > 0 && ow_n > 0) begin
      r.op = OP_COMPUTE;
      r.filt = $urandom_range(cfg_f - 1);
      r.row = $urandom_range(oh_n - 1);
      r.col = $urandom_range(ow_n - 1);
    end else if (pick < 50) begin
      r.op = OP_COMPUTE;
    end else begin
      r.value = rand_value();
      if (pick < 70) begin
        r.op = OP_LOAD_ACT;
        r.addr = $urandom_range(cfg_c * cfg_h * cfg_w - 1);
      end else if (pick < 88) begin
        r.op = OP_LOAD_WGT;
        r.addr = $urandom_range(cfg_f * cfg_c * cfg_kh * cfg_kw - 1);
      end else begin
        r.op = OP_LOAD_BIAS;
        r.addr = $urandom_range(cfg_f - 1);
      end
      // Now and then a load lands anywhere, including beyond its store.
      if ($urandom_range(9) == 0) r.addr = $urandom;
    end
    return r;
  endfunction

  // Waits until every request has been sent and every result has come back.
  task automatic drain();
    while (request_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IN_CHANNELS:   cfg_c = clamp(data & 6'h1F, 1, 16);
      REG_IN_HEIGHT:     cfg_h = clamp(data, 1, 32);
      REG_IN_WIDTH:      cfg_w = clamp(data, 1, 32);
      REG_FILTER_COUNT:  cfg_f = clamp(data & 6'h1F, 1, 16);
      REG_KERNEL_HEIGHT: cfg_kh = clamp(data & 6'h07, 1, 7);
      REG_KERNEL_WIDTH:  cfg_kw = clamp(data & 6'h07, 1, 7);
      REG_STRIDE_STEP:   cfg_s = clamp(data & 6'h0F, 1, 8);
      REG_ZERO_PAD:      cfg_p = clamp(data & 6'h07, 0, 6);
      default: ;
    endcase
  endtask

  task automatic write_config(int c, int h, int w, int f, int kh, int kw, int s, int p);
    write_reg(REG_IN_CHANNELS, c);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_FILTER_COUNT, f);
    write_reg(REG_KERNEL_HEIGHT, kh);
    write_reg(REG_KERNEL_WIDTH, kw);
    write_reg(REG_STRIDE_STEP, s);
    write_reg(REG_ZERO_PAD, p);
  endtask

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // Request driver: an accepted transfer updates the shadow stores or queues a prediction.
  always @(posedge clk) begin : drive_requests
    conv_req_t r;
    int addr;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        addr = s_tdata[13:0];
        case (s_tuser)
          OP_LOAD_ACT:  act_image[addr] = s_tdata[29:14];
          OP_LOAD_WGT:  if (addr < WGT_DEPTH) filter_weights[addr] = s_tdata[29:14];
          OP_LOAD_BIAS: if (addr < BIAS_DEPTH) filter_bias[addr] = s_tdata[29:14];
          default: begin
            r = '0;
            r.filt = s_tdata[33:30];
            r.row = s_tdata[39:34];
            r.col = s_tdata[45:40];
            expected_sums.push_back(conv_point(r));
          end
        endcase
      end
      if (!s_tvalid || s_tready) begin
        if (request_queue.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
          r = request_queue.pop_front();
          s_tdata <= {2'b00, r.col, r.row, r.filt, r.value, r.addr};
          s_tuser <= r.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : check_results
    conv_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_sums.size() == 0) begin
          note_mismatch($sformatf("unexpected result: sum %h out_of_range %b",
                                  m_tdata, m_tuser[0]));
        end else begin
          want = expected_sums.pop_front();
          if (m_tdata !== want.sum)
            note_mismatch($sformatf("sum mismatch: expected %h, got %h", want.sum, m_tdata));
          if (m_tuser[0] !== want.oor)
            note_mismatch($sformatf("out_of_range mismatch: expected %b, got %b",
                                    want.oor, m_tuser[0]));
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 26);
    end
  end

  // Watchdog: ends the run if no transfer or register write happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** conv2d_output_engine_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (filter_bias[i]) filter_bias[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Write every activation and weight entry once so no compute reads an unwritten one.
    for (int a = 0; a < ACT_DEPTH; a++) queue_load(OP_LOAD_ACT, a, $urandom);
    for (int a = 0; a < WGT_DEPTH; a++) queue_load(OP_LOAD_WGT, a, $urandom);

    // Reset geometry: single tap, extremes of data, ignored loads, positions outside.
    queue_compute(0, 0, 0);
    queue_load(OP_LOAD_BIAS, 0, 16'h7FFF);
    queue_load(OP_LOAD_ACT, 0, 16'h7FFF);
    queue_load(OP_LOAD_WGT, 0, 16'h7FFF);
    queue_compute(0, 0, 0);
    queue_load(OP_LOAD_WGT, WGT_DEPTH, 16'h1234);
    queue_load(OP_LOAD_BIAS, BIAS_DEPTH, 16'h1234);
    queue_load(OP_LOAD_BIAS, 16383, 16'h4321);
    queue_compute(0, 0, 0);
    queue_compute(15, 0, 0);
    queue_compute(0, 63, 63);
    queue_compute(0, 0, 1);
    drain();

    // Four channels of full-scale products saturate in both directions.
    write_config(4, 1, 1, 1, 1, 1, 1, 0);
    queue_load(OP_LOAD_BIAS, 0, 16'h8000);
    for (int c = 0; c < 4; c++) begin
      queue_load(OP_LOAD_ACT, c, 16'h8000);
      queue_load(OP_LOAD_WGT, c, 16'h8000);
    end
    queue_compute(0, 0, 0);
    for (int c = 0; c < 4; c++) queue_load(OP_LOAD_WGT, c, 16'h7FFF);
    queue_compute(0, 0, 0);
    drain();

    // Random phases: clamped lows, clamped highs, a kernel wider than the padded
    // input, then random geometries; one phase runs without any idling.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_config(0, 0, 0, 0, 0, 0, 0, 0);
        1: write_config(31, 63, 63, 31, 7, 7, 15, 7);
        2: write_config(3, 2, 2, 4, 7, 7, 1, 1);
        default: write_config($urandom_range(1, 16), $urandom_range(1, 32),
                              $urandom_range(1, 32), $urandom_range(1, 16),
                              $urandom_range(1, 7), $urandom_range(1, 7),
                              $urandom_range(1, 8), $urandom_range(0, 6));
      endcase
      calm = (ph == 3);
      repeat (75) request_queue.push_back(random_request());
      drain();
    end
    calm = 1'b0;

    if (mismatch_count == 0) begin
      $display("** conv2d_output_engine_core: PASSED **");
    end else begin
      $display("** conv2d_output_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
